### design/ots_pkg.sv
// Shared types and constants for the operation timing scoreboard.
// Used by ots_latency and op_timing_scoreboard; depends on nothing.
`default_nettype none

package ots_pkg;

    // Operation codes; codes above OP_FENCE are no-ops
    typedef enum logic [3:0] {
        OP_MSET      = 4'd0,
        OP_MVIN      = 4'd1,
        OP_MVOUT     = 4'd2,
        OP_MATMUL    = 4'd3,
        OP_BIAS      = 4'd4,
        OP_IM2COL    = 4'd5,
        OP_QUANT_F32 = 4'd6,
        OP_QUANT_I32 = 4'd7,
        OP_TRANSPOSE = 4'd8,
        OP_FENCE     = 4'd9
    } op_t;

    // Execution units
    localparam int NUM_UNITS = 6;
    localparam logic [2:0] UNIT_MATMUL    = 3'd0;
    localparam logic [2:0] UNIT_IM2COL    = 3'd1;
    localparam logic [2:0] UNIT_QUANT     = 3'd2;
    localparam logic [2:0] UNIT_TRANSPOSE = 3'd3;
    localparam logic [2:0] UNIT_MVIN      = 3'd4;
    localparam logic [2:0] UNIT_MVOUT     = 3'd5;

    // Latency word width and matmul tile shift (tile of 16)
    localparam int LAT_W      = 36;
    localparam int TILE_SHIFT = 4;

    // Stream widths
    localparam int ITEM_W      = 86;
    localparam int S_TDATA_W   = 88;
    localparam int OUT_FIELD_W = 48;
    localparam int M_TDATA_W   = 6 * OUT_FIELD_W;

    // One operation, last field in the lowest bits
    typedef struct packed {
        logic        write_valid;
        logic [5:0]  write_bank;
        logic        read_b_valid;
        logic [5:0]  read_bank_b;
        logic        read_a_valid;
        logic [5:0]  read_bank_a;
        logic [35:0] matmul_shape;
        logic [7:0]  kernel_size;
        logic        size_known;
        logic [15:0] amount;
        logic [3:0]  operation;
    } item_t;

    typedef struct packed {
        logic       used;
        logic [2:0] idx;
    } unit_sel_t;

    // Map an operation to the unit it occupies
    function automatic unit_sel_t unit_of(logic [3:0] op);
        unit_sel_t u;
        u = '{used: 1'b1, idx: UNIT_MATMUL};
        unique case (op)
            OP_MVIN:      u.idx = UNIT_MVIN;
            OP_MVOUT:     u.idx = UNIT_MVOUT;
            OP_MATMUL:    u.idx = UNIT_MATMUL;
            OP_BIAS:      u.idx = UNIT_MATMUL;
            OP_IM2COL:    u.idx = UNIT_IM2COL;
            OP_QUANT_F32: u.idx = UNIT_QUANT;
            OP_QUANT_I32: u.idx = UNIT_QUANT;
            OP_TRANSPOSE: u.idx = UNIT_TRANSPOSE;
            default:      u.used = 1'b0;
        endcase
        return u;
    endfunction

endpackage

`default_nettype wire

### design/ots_bank_mem.sv
// Bank ready-time memory: one write port, one registered read port.
// Standalone; no package dependency.
`default_nettype none

module ots_bank_mem #(
    parameter int DEPTH = 64,
    parameter int AW    = 6,
    parameter int DW    = 48
) (
    input  wire logic          aclk,
    input  wire logic          we,
    input  wire logic [AW-1:0] waddr,
    input  wire logic [DW-1:0] wdata,
    input  wire logic [AW-1:0] raddr,
    output logic      [DW-1:0] rdata
);

    logic [DW-1:0] mem [DEPTH];

    // Write port
    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
    end

    // Registered read port
    always_ff @(posedge aclk) begin
        rdata <= mem[raddr];
    end

endmodule

`default_nettype wire

### design/ots_latency.sv
// Latency unit: two registered multiply stages, then per-kind selection.
// Depends on ots_pkg for the item layout and operation codes.
`default_nettype none

module ots_latency (
    input  wire logic                      aclk,
    input  wire ots_pkg::item_t            item,
    output logic [ots_pkg::LAT_W-1:0]      lat
);

    logic [23:0] rc_reg;
    logic [23:0] ak_reg;
    logic [11:0] k_reg;
    logic [7:0]  ks_reg;
    logic [35:0] rck_reg;
    logic [23:0] rc2_reg;
    logic [31:0] akk_reg;
    logic [15:0] amin;

    // First products: rows*cols and amount*kernel
    always_ff @(posedge aclk) begin
        rc_reg <= item.matmul_shape[11:0] * item.matmul_shape[23:12];
        ak_reg <= item.amount * item.kernel_size;
        k_reg  <= item.matmul_shape[35:24];
        ks_reg <= item.kernel_size;
    end

    // Second products
    always_ff @(posedge aclk) begin
        rck_reg <= rc_reg * k_reg;
        rc2_reg <= rc_reg;
        akk_reg <= ak_reg * ks_reg;
    end

    assign amin = (item.amount == 16'd0) ? 16'd1 : item.amount;

    // Pick the latency of this kind
    always_comb begin
        lat = '0;
        unique case (item.operation)
            ots_pkg::OP_MSET, ots_pkg::OP_BIAS, ots_pkg::OP_FENCE: begin
                lat = (item.operation == ots_pkg::OP_BIAS) ? 36'd4 : 36'd1;
            end
            ots_pkg::OP_MVIN, ots_pkg::OP_MVOUT, ots_pkg::OP_QUANT_F32: begin
                lat = item.size_known ? 36'(amin) : '0;
            end
            ots_pkg::OP_QUANT_I32: begin
                lat = item.size_known ? 36'(amin) + 36'd4 : '0;
            end
            ots_pkg::OP_MATMUL: begin
                lat = item.size_known
                    ? 36'(rck_reg >> ots_pkg::TILE_SHIFT) + 36'(rc2_reg >> 1) : '0;
            end
            ots_pkg::OP_IM2COL: begin
                if (item.size_known && item.amount != 16'd0) begin
                    lat = (akk_reg < 32'd16) ? 36'd16 : 36'(akk_reg);
                end
            end
            ots_pkg::OP_TRANSPOSE: begin
                lat = item.size_known ? 36'({item.amount, 5'b0}) : '0;
            end
            default: lat = '0;
        endcase
    end

endmodule

`default_nettype wire

### design/op_timing_scoreboard.sv
// Top level of the operation timing scoreboard.
// Depends on ots_pkg, ots_latency and ots_bank_mem.
//
//  Channel | Direction | Ports                       | Content
//  --------+-----------+-----------------------------+---------------------------
//  s_      | in        | s_tvalid s_tready s_tdata   | one operation per transfer
//  m_      | out       | m_tvalid m_tready m_tdata   | timing and totals per op
//
// Each operation passes through acceptance, three reads of the single bank
// memory read port, a bank-max step, a start/stall step and the update.
// After reset a clearing pass writes every bank entry, with s_tready low.
// The result sits in an output register; the update waits only while that
// register is still full and m_tready is low.
`default_nettype none

module op_timing_scoreboard #(
    parameter int NUM_BANKS = 64,
    parameter int TIME_BITS = 48
) (
    input  wire logic                            aclk,
    input  wire logic                            aresetn,
    input  wire logic                            s_tvalid,
    output logic                                 s_tready,
    // operation[3:0] amount[19:4] size_known[20] kernel_size[28:21]
    // matmul_shape[64:29] read_bank_a[70:65] read_a_valid[71]
    // read_bank_b[77:72] read_b_valid[78] write_bank[84:79] write_valid[85]
    input  wire logic [ots_pkg::S_TDATA_W-1:0]   s_tdata,
    output logic                                 m_tvalid,
    input  wire logic                            m_tready,
    // start_time[47:0] finish_time[95:48] stall_cycles[143:96]
    // total_time[191:144] total_stall[239:192] fence_stall[287:240]
    output logic [ots_pkg::M_TDATA_W-1:0]        m_tdata
);

    localparam int AW    = (NUM_BANKS > 1) ? $clog2(NUM_BANKS) : 1;
    localparam int EXT_W = 6 + AW;
    localparam int SW    = ((TIME_BITS > ots_pkg::LAT_W) ? TIME_BITS : ots_pkg::LAT_W) + 1;
    localparam logic [TIME_BITS-1:0] TMAX    = {TIME_BITS{1'b1}};
    localparam logic [SW-1:0]        TMAX_SW = {{(SW-TIME_BITS){1'b0}}, {TIME_BITS{1'b1}}};

    typedef enum logic [7:0] {
        ST_CLEAR = 8'b0000_0001,
        ST_IDLE  = 8'b0000_0010,
        ST_RDA   = 8'b0000_0100,
        ST_RDB   = 8'b0000_1000,
        ST_RDW   = 8'b0001_0000,
        ST_MAXB  = 8'b0010_0000,
        ST_START = 8'b0100_0000,
        ST_UPD   = 8'b1000_0000
    } state_t;

    state_t                       state_reg, state_next;
    logic [AW-1:0]                clr_cnt_reg;
    ots_pkg::item_t               item_reg;
    logic [TIME_BITS-1:0]         a_reg, b_reg, bready_reg, start_reg, stall_reg;
    logic [TIME_BITS-1:0]         unit_ready_reg [ots_pkg::NUM_UNITS];
    logic [TIME_BITS-1:0]         drain_reg, overall_reg, stall_sum_reg, fence_sum_reg;
    logic                         m_valid_reg;
    logic [ots_pkg::M_TDATA_W-1:0] m_data_reg;

    logic                         mem_we;
    logic [AW-1:0]                mem_waddr, mem_raddr;
    logic [TIME_BITS-1:0]         mem_wdata, mem_rdata;
    logic [ots_pkg::LAT_W-1:0]    lat;
    ots_pkg::unit_sel_t           usel;
    logic                         is_fence, is_noop, out_free, do_upd;
    logic                         wr_bank;
    logic [TIME_BITS-1:0]         w_val, bmax_ab, uready;
    logic [TIME_BITS-1:0]         st, stl, fin, stall_add;
    logic [SW-1:0]                fin_sum;
    logic [TIME_BITS:0]           ss_sum, fs_sum;

    function automatic logic [AW-1:0] baddr(logic [5:0] b);
        logic [EXT_W-1:0] e;
        e = {{AW{1'b0}}, b};
        return e[AW-1:0];
    endfunction

    function automatic logic in_range(logic [5:0] b);
        logic [EXT_W-1:0] e;
        e = {{AW{1'b0}}, b};
        return e < EXT_W'(NUM_BANKS);
    endfunction

    function automatic logic [ots_pkg::OUT_FIELD_W-1:0] to_out(logic [TIME_BITS-1:0] v);
        logic [TIME_BITS+ots_pkg::OUT_FIELD_W-1:0] e;
        e = {{ots_pkg::OUT_FIELD_W{1'b0}}, v};
        return e[ots_pkg::OUT_FIELD_W-1:0];
    endfunction

    function automatic logic [TIME_BITS-1:0] tmax2(logic [TIME_BITS-1:0] x,
                                                   logic [TIME_BITS-1:0] y);
        return (x > y) ? x : y;
    endfunction

    ots_latency u_latency (
        .aclk (aclk),
        .item (item_reg),
        .lat  (lat)
    );

    ots_bank_mem #(
        .DEPTH (NUM_BANKS),
        .AW    (AW),
        .DW    (TIME_BITS)
    ) u_bank_mem (
        .aclk  (aclk),
        .we    (mem_we),
        .waddr (mem_waddr),
        .wdata (mem_wdata),
        .raddr (mem_raddr),
        .rdata (mem_rdata)
    );

    assign s_tready = (state_reg == ST_IDLE);
    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;

    assign usel     = ots_pkg::unit_of(item_reg.operation);
    assign is_fence = (item_reg.operation == ots_pkg::OP_FENCE);
    assign is_noop  = (item_reg.operation > ots_pkg::OP_FENCE);
    assign out_free = !m_valid_reg || m_tready;
    assign do_upd   = (state_reg == ST_UPD) && out_free;
    assign wr_bank  = !is_fence && !is_noop && item_reg.write_valid
                      && in_range(item_reg.write_bank);

    // Select the read address for the current read cycle
    always_comb begin
        priority if (state_reg == ST_RDA) begin
            mem_raddr = baddr(item_reg.read_bank_a);
        end else if (state_reg == ST_RDB) begin
            mem_raddr = baddr(item_reg.read_bank_b);
        end else begin
            mem_raddr = baddr(item_reg.write_bank);
        end
    end

    // Bank write: clearing pass or finish time of the written bank
    always_comb begin
        if (state_reg == ST_CLEAR) begin
            mem_we    = 1'b1;
            mem_waddr = clr_cnt_reg;
            mem_wdata = '0;
        end else begin
            mem_we    = do_upd && wr_bank;
            mem_waddr = baddr(item_reg.write_bank);
            mem_wdata = fin;
        end
    end

    // Bank and unit readiness, start and stall
    assign w_val   = (item_reg.write_valid && in_range(item_reg.write_bank)) ? mem_rdata : '0;
    assign bmax_ab = tmax2(a_reg, b_reg);
    assign uready  = usel.used ? unit_ready_reg[usel.idx] : '0;

    // Finish time and running sums for the update cycle
    always_comb begin
        if (is_noop) begin
            st  = '0;
            stl = '0;
        end else if (is_fence) begin
            st  = drain_reg;
            stl = '0;
        end else begin
            st  = start_reg;
            stl = stall_reg;
        end
        fin_sum   = SW'(st) + SW'(lat);
        fin       = is_noop ? '0 : ((fin_sum > TMAX_SW) ? TMAX : fin_sum[TIME_BITS-1:0]);
        stall_add = is_fence ? st : stl;
        ss_sum    = {1'b0, stall_sum_reg} + {1'b0, stall_add};
        fs_sum    = {1'b0, fence_sum_reg} + {1'b0, st};
    end

    // Advance the sequencer
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_CLEAR: if (clr_cnt_reg == AW'(NUM_BANKS - 1)) state_next = ST_IDLE;
            ST_IDLE:  if (s_tvalid) state_next = ST_RDA;
            ST_RDA:   state_next = ST_RDB;
            ST_RDB:   state_next = ST_RDW;
            ST_RDW:   state_next = ST_MAXB;
            ST_MAXB:  state_next = ST_START;
            ST_START: state_next = ST_UPD;
            ST_UPD:   if (out_free) state_next = ST_IDLE;
            default:  state_next = ST_CLEAR;
        endcase
    end

    // Control state and timing state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_CLEAR;
            clr_cnt_reg   <= '0;
            m_valid_reg   <= 1'b0;
            drain_reg     <= '0;
            overall_reg   <= '0;
            stall_sum_reg <= '0;
            fence_sum_reg <= '0;
            for (int i = 0; i < ots_pkg::NUM_UNITS; i++) begin
                unit_ready_reg[i] <= '0;
            end
        end else begin
            state_reg <= state_next;
            if (state_reg == ST_CLEAR) begin
                clr_cnt_reg <= clr_cnt_reg + AW'(1);
            end
            // Load a new result, or drop the one taken by the receiver
            if (do_upd) begin
                m_valid_reg <= 1'b1;
            end else if (m_tready) begin
                m_valid_reg <= 1'b0;
            end
            if (do_upd) begin
                overall_reg   <= tmax2(overall_reg, fin);
                stall_sum_reg <= ss_sum[TIME_BITS] ? TMAX : ss_sum[TIME_BITS-1:0];
                if (is_fence) begin
                    fence_sum_reg <= fs_sum[TIME_BITS] ? TMAX : fs_sum[TIME_BITS-1:0];
                end
                if (!is_fence && !is_noop && usel.used) begin
                    unit_ready_reg[usel.idx] <= fin;
                end
                if (wr_bank || (!is_fence && !is_noop && usel.used)) begin
                    drain_reg <= tmax2(drain_reg, fin);
                end
            end
        end
    end

    // Payload: item capture, read data capture, result word
    always_ff @(posedge aclk) begin
        if (s_tvalid && s_tready) begin
            item_reg <= ots_pkg::item_t'(s_tdata[ots_pkg::ITEM_W-1:0]);
        end
        if (state_reg == ST_RDB) begin
            a_reg <= (item_reg.read_a_valid && in_range(item_reg.read_bank_a))
                     ? mem_rdata : '0;
        end
        if (state_reg == ST_RDW) begin
            b_reg <= (item_reg.read_b_valid && in_range(item_reg.read_bank_b))
                     ? mem_rdata : '0;
        end
        if (state_reg == ST_MAXB) begin
            bready_reg <= tmax2(bmax_ab, w_val);
        end
        if (state_reg == ST_START) begin
            start_reg <= tmax2(bready_reg, uready);
            stall_reg <= (bready_reg > uready) ? bready_reg - uready : '0;
        end
        if (do_upd) begin
            m_data_reg <= {
                to_out(is_fence
                       ? (fs_sum[TIME_BITS] ? TMAX : fs_sum[TIME_BITS-1:0])
                       : fence_sum_reg),
                to_out(ss_sum[TIME_BITS] ? TMAX : ss_sum[TIME_BITS-1:0]),
                to_out(tmax2(overall_reg, fin)),
                to_out(stl),
                to_out(fin),
                to_out(st)
            };
        end
    end

endmodule

`default_nettype wire

### verif/op_timing_checker.sv
// Watches both streams of the operation timing scoreboard, predicts each
// result from the accepted operations and compares. Depends on ots_pkg.
`default_nettype none

module op_timing_checker (
    input  wire logic                          aclk,
    input  wire logic                          aresetn,
    input  wire logic                          s_tvalid,
    input  wire logic                          s_tready,
    input  wire logic [ots_pkg::S_TDATA_W-1:0] s_tdata,
    input  wire logic                          m_tvalid,
    input  wire logic                          m_tready,
    input  wire logic [ots_pkg::M_TDATA_W-1:0] m_tdata,
    output int                                 fail_count,
    output int                                 pending_count,
    output int                                 result_count
);

    localparam logic [63:0] TMAX = 64'h0000_FFFF_FFFF_FFFF;
    localparam int QDEPTH = 64;

    logic [63:0] bank_rdy [64];
    logic [63:0] unit_rdy [ots_pkg::NUM_UNITS];
    logic [63:0] peak_finish, stall_acc, fence_acc;
    logic [ots_pkg::M_TDATA_W-1:0] timing_fifo [QDEPTH];
    int wr_cnt, rd_cnt;

    function automatic logic [63:0] sadd(logic [63:0] a, logic [63:0] b);
        logic [64:0] s;
        s = {1'b0, a} + {1'b0, b};
        return (s > {1'b0, TMAX}) ? TMAX : s[63:0];
    endfunction

    function automatic logic [63:0] umax(logic [63:0] a, logic [63:0] b);
        return (a > b) ? a : b;
    endfunction

    // Advance the timing state by one operation and return the expected result
    function automatic logic [ots_pkg::M_TDATA_W-1:0] time_op(ots_pkg::item_t it);
        logic [63:0] lat, start, stall, fin, amin, bready, uready, r, c, k;
        int unit;
        logic fence, noop;
        lat = 0; start = 0; stall = 0; unit = -1; fence = 0; noop = 0;
        amin = (it.amount != 0) ? 64'(it.amount) : 64'd1;
        r = 64'(it.matmul_shape[11:0]);
        c = 64'(it.matmul_shape[23:12]);
        k = 64'(it.matmul_shape[35:24]);
        case (it.operation)
            ots_pkg::OP_MSET:      lat = 1;
            ots_pkg::OP_MVIN:      begin
                lat = it.size_known ? amin : 0; unit = ots_pkg::UNIT_MVIN;
            end
            ots_pkg::OP_MVOUT:     begin
                lat = it.size_known ? amin : 0; unit = ots_pkg::UNIT_MVOUT;
            end
            ots_pkg::OP_MATMUL:    begin
                lat = it.size_known ? (r * c * k) / 16 + (r * c) / 2 : 0;
                unit = ots_pkg::UNIT_MATMUL;
            end
            ots_pkg::OP_BIAS:      begin lat = 4; unit = ots_pkg::UNIT_MATMUL; end
            ots_pkg::OP_IM2COL:    begin
                lat = (it.size_known && it.amount != 0) ?
                    umax(64'(it.amount) * it.kernel_size * it.kernel_size, 16) : 0;
                unit = ots_pkg::UNIT_IM2COL;
            end
            ots_pkg::OP_QUANT_F32: begin
                lat = it.size_known ? amin : 0; unit = ots_pkg::UNIT_QUANT;
            end
            ots_pkg::OP_QUANT_I32: begin
                lat = it.size_known ? amin + 4 : 0; unit = ots_pkg::UNIT_QUANT;
            end
            ots_pkg::OP_TRANSPOSE: begin
                lat = it.size_known ? 64'(it.amount) * 32 : 0;
                unit = ots_pkg::UNIT_TRANSPOSE;
            end
            ots_pkg::OP_FENCE:     begin lat = 1; fence = 1; end
            default:               noop = 1;
        endcase
        if (lat > TMAX) lat = TMAX;
        if (noop) begin
            fin = 0;
        end else if (fence) begin
            foreach (bank_rdy[i]) start = umax(start, bank_rdy[i]);
            foreach (unit_rdy[i]) start = umax(start, unit_rdy[i]);
            fence_acc = sadd(fence_acc, start);
            stall_acc = sadd(stall_acc, start);
            fin = sadd(start, lat);
        end else begin
            bready = 0;
            uready = 0;
            if (it.read_a_valid) bready = umax(bready, bank_rdy[it.read_bank_a]);
            if (it.read_b_valid) bready = umax(bready, bank_rdy[it.read_bank_b]);
            if (it.write_valid) bready = umax(bready, bank_rdy[it.write_bank]);
            if (unit >= 0) uready = unit_rdy[unit];
            start = umax(bready, uready);
            stall = (bready > uready) ? bready - uready : 0;
            stall_acc = sadd(stall_acc, stall);
            fin = sadd(start, lat);
            if (it.write_valid) bank_rdy[it.write_bank] = fin;
            if (unit >= 0) unit_rdy[unit] = fin;
        end
        peak_finish = umax(peak_finish, fin);
        return {fence_acc[47:0], stall_acc[47:0], peak_finish[47:0],
                stall[47:0], fin[47:0], start[47:0]};
    endfunction

    // Predict on each input transfer, compare on each output transfer
    always @(posedge aclk) begin
        logic [ots_pkg::M_TDATA_W-1:0] want;
        if (!aresetn) begin
            foreach (bank_rdy[i]) bank_rdy[i] = 0;
            foreach (unit_rdy[i]) unit_rdy[i] = 0;
            peak_finish = 0;
            stall_acc = 0;
            fence_acc = 0;
            wr_cnt = 0;
            rd_cnt = 0;
            fail_count <= 0;
            result_count <= 0;
        end else begin
            if (s_tvalid && s_tready) begin
                timing_fifo[wr_cnt % QDEPTH] =
                    time_op(ots_pkg::item_t'(s_tdata[ots_pkg::ITEM_W-1:0]));
                wr_cnt++;
            end
            if (m_tvalid && m_tready) begin
                result_count <= result_count + 1;
                if (wr_cnt == rd_cnt) begin
                    if (fail_count < 10)
                        $display("ERROR: result with none expected: %h", m_tdata);
                    fail_count <= fail_count + 1;
                end else begin
                    want = timing_fifo[rd_cnt % QDEPTH];
                    rd_cnt++;
                    if (want !== m_tdata) begin
                        if (fail_count < 10)
                            $display({"ERROR: result %0d\n  exp start %h fin %h stall %h",
                                      " tot %h tstall %h fence %h\n  got start %h fin %h",
                                      " stall %h tot %h tstall %h fence %h"},
                                     result_count,
                                     want[47:0], want[95:48], want[143:96], want[191:144],
                                     want[239:192], want[287:240],
                                     m_tdata[47:0], m_tdata[95:48], m_tdata[143:96],
                                     m_tdata[191:144], m_tdata[239:192], m_tdata[287:240]);
                        fail_count <= fail_count + 1;
                    end
                end
            end
        end
        pending_count <= wr_cnt - rd_cnt;
    end

endmodule

`default_nettype wire

### verif/op_timing_scoreboard_tb.sv
// Testbench top for the operation timing scoreboard: clock, reset, stimulus
// and verdict. Depends on ots_pkg, op_timing_scoreboard and op_timing_checker.
`default_nettype none

module op_timing_scoreboard_tb;

    localparam int IDLE_LIMIT = 20000;

    logic aclk = 0;
    logic aresetn = 0;
    logic s_tvalid = 0;
    logic s_tready;
    logic [ots_pkg::S_TDATA_W-1:0] s_tdata = '0;
    logic m_tvalid;
    logic m_tready = 0;
    logic [ots_pkg::M_TDATA_W-1:0] m_tdata;
    int fail_count, pending_count, result_count;
    int send_idle_pct = 0, recv_stall_pct = 0;
    bit hold_off = 0;
    int idle_cycles = 0;
    int ops_sent = 0;

    op_timing_scoreboard dut (
        .aclk(aclk), .aresetn(aresetn),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata)
    );

    op_timing_checker chk (
        .aclk(aclk), .aresetn(aresetn),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
        .fail_count(fail_count), .pending_count(pending_count),
        .result_count(result_count)
    );

    always begin
        #5 aclk = 1;
        #5 aclk = 0;
    end

    // Receiver: random stalls, or a long hold-off when asked
    always @(negedge aclk) begin
        m_tready <= !hold_off && ($urandom_range(99) >= recv_stall_pct);
    end

    // Watchdog on cycles without any transfer
    always @(posedge aclk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= IDLE_LIMIT) begin
            $display("Watchdog expired, %0d results pending", pending_count);
            $display("Simulation FAILED");
            $finish;
        end
    end

    // Offer one operation, with optional idle gaps, until accepted; the
    // valid stays up afterwards until the next gap or the next drain
    task automatic send_op(ots_pkg::item_t it);
        while ($urandom_range(99) < send_idle_pct) begin
            s_tvalid <= 0;
            @(negedge aclk);
        end
        s_tvalid <= 1;
        s_tdata <= ots_pkg::S_TDATA_W'(it);
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        ops_sent++;
        @(negedge aclk);
    endtask

    function automatic ots_pkg::item_t rand_op();
        ots_pkg::item_t it;
        it = ots_pkg::item_t'(ots_pkg::ITEM_W'({$urandom, $urandom, $urandom}));
        it.operation = ($urandom_range(19) == 0) ? 4'($urandom_range(15, 10))
                                                 : 4'($urandom_range(9));
        it.size_known = ($urandom_range(9) != 0);
        // Mostly small sizes so that times grow slowly; a few huge ones
        if ($urandom_range(15) != 0) begin
            it.amount = 16'($urandom_range(64));
            it.kernel_size = 8'($urandom_range(5));
            it.matmul_shape = {12'($urandom_range(32)), 12'($urandom_range(32)),
                               12'($urandom_range(32))};
        end
        // Reuse a few banks so that dependencies are common
        if ($urandom_range(3) != 0) begin
            it.read_bank_a = 6'($urandom_range(7));
            it.read_bank_b = 6'($urandom_range(7));
            it.write_bank = 6'($urandom_range(7));
        end
        return it;
    endfunction

    function automatic ots_pkg::item_t mk(ots_pkg::op_t op, logic [15:0] amt, logic known,
                                          logic [7:0] ks, logic [35:0] shape);
        ots_pkg::item_t it;
        it = '0;
        it.operation = op;
        it.amount = amt;
        it.size_known = known;
        it.kernel_size = ks;
        it.matmul_shape = shape;
        it.read_bank_a = 6'd1;
        it.read_a_valid = 1;
        it.read_bank_b = 6'd63;
        it.read_b_valid = 1;
        it.write_bank = 6'd2;
        it.write_valid = 1;
        return it;
    endfunction

    // Stop offering and wait until every expected result has come
    task automatic drain();
        s_tvalid <= 0;
        while (pending_count != 0 || (s_tvalid && s_tready)) @(posedge aclk);
        @(negedge aclk);
    endtask

    initial begin
        ots_pkg::item_t it;
        repeat (6) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1;

        // Directed: every kind, size extremes, unknown sizes, no-ops, fences
        send_op(mk(ots_pkg::OP_MSET, 0, 0, 0, 0));
        send_op(mk(ots_pkg::OP_MVIN, 0, 1, 0, 0));
        send_op(mk(ots_pkg::OP_MVIN, 16'hFFFF, 1, 0, 0));
        send_op(mk(ots_pkg::OP_MVOUT, 16'hFFFF, 0, 0, 0));
        send_op(mk(ots_pkg::OP_MATMUL, 0, 1, 0, {12'd16, 12'd8, 12'd4}));
        send_op(mk(ots_pkg::OP_MATMUL, 0, 1, 0, 36'hFFFFFFFFF));
        send_op(mk(ots_pkg::OP_MATMUL, 0, 0, 0, 36'hFFFFFFFFF));
        send_op(mk(ots_pkg::OP_BIAS, 0, 0, 0, 0));
        send_op(mk(ots_pkg::OP_IM2COL, 0, 1, 8'd3, 0));
        send_op(mk(ots_pkg::OP_IM2COL, 1, 1, 8'd1, 0));
        send_op(mk(ots_pkg::OP_IM2COL, 16'hFFFF, 1, 8'hFF, 0));
        send_op(mk(ots_pkg::OP_QUANT_F32, 7, 1, 0, 0));
        send_op(mk(ots_pkg::OP_QUANT_I32, 0, 1, 0, 0));
        send_op(mk(ots_pkg::OP_QUANT_I32, 9, 0, 0, 0));
        send_op(mk(ots_pkg::OP_TRANSPOSE, 16'hFFFF, 1, 0, 0));
        send_op(mk(ots_pkg::OP_FENCE, 0, 0, 0, 0));
        it = mk(ots_pkg::OP_MVIN, 5, 1, 0, 0);
        it.read_a_valid = 0; it.read_b_valid = 0; it.write_valid = 0;
        send_op(it);
        send_op(ots_pkg::item_t'(ots_pkg::ITEM_W'({$urandom, $urandom, 22'h0, 4'd15})));
        send_op(ots_pkg::item_t'(ots_pkg::ITEM_W'({$urandom, $urandom, 22'h0, 4'd10})));
        send_op(mk(ots_pkg::OP_FENCE, 16'hFFFF, 1, 8'hFF, 36'hFFFFFFFFF));
        drain();

        // Random phases: none, sender idle, receiver stall, both
        for (int ph = 0; ph < 4; ph++) begin
            send_idle_pct = (ph == 1 || ph == 3) ? ((ph == 3) ? 17 : 73) : 0;
            recv_stall_pct = (ph == 2 || ph == 3) ? ((ph == 3) ? 17 : 73) : 0;
            for (int n = 0; n < 240; n++) send_op(rand_op());
            // Sender pause until everything has come back
            if (ph == 1) drain();
        end
        send_idle_pct = 0;
        recv_stall_pct = 0;

        // Long receiver hold-off while the sender keeps offering
        hold_off = 1;
        fork
            begin
                repeat (300) @(negedge aclk);
                hold_off = 0;
            end
            for (int n = 0; n < 40; n++) send_op(rand_op());
        join

        drain();
        repeat (30) @(posedge aclk);
        $display("Sent %0d operations, checked %0d results, all kinds incl. fences,",
                 ops_sent, result_count);
        $display("no-op codes, saturating sizes and four handshake pressure phases");
        if (fail_count == 0 && pending_count == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

endmodule

`default_nettype wire

### sim.f
design/ots_pkg.sv
design/ots_bank_mem.sv
design/ots_latency.sv
design/op_timing_scoreboard.sv
verif/op_timing_checker.sv
verif/op_timing_scoreboard_tb.sv
